// ===== rtl/rwl_pkg.sv =====
// Shared types and constants for the reader-writer lock unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rwl_pkg;

    // Sizing of the lock and the per-thread table
    localparam int             NUM_THREADS  = 16;
    localparam int             TID_W        = 4;
    localparam logic [8:0]     READER_LIMIT = 9'd256;
    localparam logic [4:0]     WAIT_MAX     = 5'd31;
    localparam logic [9:0]     OWN_WRITE    = 10'h3FF;

    // Request opcodes
    localparam logic [2:0] OP_READ       = 3'd0;
    localparam logic [2:0] OP_TRY_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE      = 3'd2;
    localparam logic [2:0] OP_TRY_WRITE  = 3'd3;
    localparam logic [2:0] OP_UNLOCK     = 3'd4;
    localparam logic [2:0] OP_RETRY      = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_WAIT       = 3'd1;
    localparam logic [2:0] ST_BUSY       = 3'd2;
    localparam logic [2:0] ST_DEADLOCK   = 3'd3;
    localparam logic [2:0] ST_NOPERM     = 3'd4;
    localparam logic [2:0] ST_RELEASED   = 3'd5;

    // Pending wait kinds
    localparam logic [1:0] PEND_NONE     = 2'd0;
    localparam logic [1:0] PEND_READ     = 2'd1;
    localparam logic [1:0] PEND_WRITE    = 2'd2;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [TID_W-1:0] thread_id;
    } rwl_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       wake_readers;
        logic       wake_writer;
        logic [8:0] readers_now;
        logic       writer_now;
        logic       lock_idle;
    } rwl_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } rwl_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } rwl_state_t;

endpackage

// ===== rtl/reader_writer_lock_unit_top.sv =====
// Top level of the reader-writer lock unit: controller plus datapath.
// Depends on rwl_pkg, rwl_ctrl and rwl_dp.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready  in_data  (rwl_in_t)
//   out       output     out_valid/out_ready  out_data (rwl_out_t)
//   cfg       input      cfg_we               cfg_data (prefer_readers)
//
// Each item is first latched as a request, then decided against the lock state
// and thread table, and the result register is loaded.
// A new item is taken while the previous result waits, as long as that result
// is taken no later than the cycle the new item is accepted.
// Reset clears the lock counters, the thread table and the preference bit.
`timescale 1ns / 1ps

module reader_writer_lock_unit_top
    import rwl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rwl_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rwl_out_t out_data,
    input  logic     cfg_we,
    input  logic     cfg_data
);

    rwl_cmd_t cmd;

    rwl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rwl_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule

// ===== rtl/rwl_ctrl.sv =====
// Controller of the reader-writer lock unit: request sequencing and output valid.
// Depends on rwl_pkg.
`timescale 1ns / 1ps

module rwl_ctrl
    import rwl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output rwl_cmd_t cmd
);

    rwl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Take an item only when idle and the result slot is free or draining this cycle
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.exec  = (state_reg == S_EXEC);
    assign out_valid = out_valid_reg;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/rwl_dp.sv =====
// Datapath of the reader-writer lock unit: lock state, per-thread table, grant logic.
// Depends on rwl_pkg.
`timescale 1ns / 1ps

module rwl_dp
    import rwl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rwl_cmd_t cmd,
    input  rwl_in_t  in_data,
    input  logic     cfg_we,
    input  logic     cfg_data,
    output rwl_out_t out_data
);

    // Request and result registers
    rwl_in_t    req_reg;
    rwl_out_t   res_reg;

    // Lock state
    logic       prefer_reg;
    logic       writer_reg, writer_next;
    logic [8:0] readers_reg, readers_next;
    logic [4:0] wait_r_reg, wait_r_next;
    logic [4:0] wait_w_reg, wait_w_next;
    logic [9:0] owned_reg [NUM_THREADS];
    logic [1:0] pend_reg  [NUM_THREADS];

    logic [9:0] own, own_next;
    logic [1:0] pend, pend_next;
    logic       read_blocked, write_blocked;
    logic [2:0] status;
    logic       wake_r, wake_w;
    logic [TID_W-1:0] tid;
    logic [2:0] op;

    assign tid  = req_reg.thread_id;
    assign op   = req_reg.opcode;
    assign own  = owned_reg[tid];
    assign pend = pend_reg[tid];

    assign read_blocked  = writer_reg || (readers_reg >= READER_LIMIT)
                           || (!prefer_reg && (wait_w_reg != 5'd0));
    assign write_blocked = writer_reg || (readers_reg != 9'd0)
                           || (prefer_reg && (wait_r_reg != 5'd0));

    // Decide the request against the current lock state
    always_comb
    begin
        writer_next  = writer_reg;
        readers_next = readers_reg;
        wait_r_next  = wait_r_reg;
        wait_w_next  = wait_w_reg;
        own_next     = own;
        pend_next    = pend;
        status       = ST_NOPERM;
        wake_r       = 1'b0;
        wake_w       = 1'b0;

        if ((9'(tid) < 9'(NUM_THREADS)) && (op <= OP_RETRY))
        begin
            if ((op <= OP_TRY_WRITE) && (pend != PEND_NONE))
            begin
                status = ST_BUSY;
            end
            else if (op <= OP_TRY_READ)
            begin
                if (own == OWN_WRITE)
                begin
                    status = ST_DEADLOCK;
                end
                else if (!read_blocked)
                begin
                    readers_next = readers_reg + 9'd1;
                    own_next     = own + 10'd1;
                    status       = ST_GRANTED;
                end
                else if ((op == OP_READ) && (wait_r_reg < WAIT_MAX))
                begin
                    wait_r_next = wait_r_reg + 5'd1;
                    pend_next   = PEND_READ;
                    status      = ST_WAIT;
                end
                else
                begin
                    status = ST_BUSY;
                end
            end
            else if (op <= OP_TRY_WRITE)
            begin
                if (own != 10'd0)
                begin
                    status = ST_DEADLOCK;
                end
                else if (!write_blocked)
                begin
                    writer_next = 1'b1;
                    own_next    = OWN_WRITE;
                    status      = ST_GRANTED;
                end
                else if ((op == OP_WRITE) && (wait_w_reg < WAIT_MAX))
                begin
                    wait_w_next = wait_w_reg + 5'd1;
                    pend_next   = PEND_WRITE;
                    status      = ST_WAIT;
                end
                else
                begin
                    status = ST_BUSY;
                end
            end
            else if (op == OP_UNLOCK)
            begin
                if (writer_reg)
                begin
                    if (own == OWN_WRITE)
                    begin
                        own_next    = 10'd0;
                        writer_next = 1'b0;
                        status      = ST_RELEASED;
                        if (prefer_reg)
                        begin
                            if (wait_r_reg != 5'd0)      wake_r = 1'b1;
                            else if (wait_w_reg != 5'd0) wake_w = 1'b1;
                        end
                        else
                        begin
                            if (wait_w_reg != 5'd0)      wake_w = 1'b1;
                            else if (wait_r_reg != 5'd0) wake_r = 1'b1;
                        end
                    end
                end
                else if (readers_reg != 9'd0)
                begin
                    if ((own != 10'd0) && (own != OWN_WRITE))
                    begin
                        own_next     = own - 10'd1;
                        readers_next = readers_reg - 9'd1;
                        status       = ST_RELEASED;
                        // Last reader out may hand over to a writer
                        if (prefer_reg)
                        begin
                            if (wait_r_reg != 5'd0)
                                wake_r = 1'b1;
                            else if ((readers_reg == 9'd1) && (wait_w_reg != 5'd0))
                                wake_w = 1'b1;
                        end
                        else
                        begin
                            if ((readers_reg == 9'd1) && (wait_w_reg != 5'd0))
                                wake_w = 1'b1;
                            else if (wait_r_reg != 5'd0)
                                wake_r = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                // Retry re-tests the grant for the pending kind
                if (pend == PEND_READ)
                begin
                    if (read_blocked)
                    begin
                        status = ST_WAIT;
                    end
                    else
                    begin
                        if (wait_r_reg != 5'd0) wait_r_next = wait_r_reg - 5'd1;
                        pend_next    = PEND_NONE;
                        readers_next = readers_reg + 9'd1;
                        own_next     = own + 10'd1;
                        status       = ST_GRANTED;
                    end
                end
                else if (pend == PEND_WRITE)
                begin
                    if (write_blocked)
                    begin
                        status = ST_WAIT;
                    end
                    else
                    begin
                        if (wait_w_reg != 5'd0) wait_w_next = wait_w_reg - 5'd1;
                        pend_next   = PEND_NONE;
                        writer_next = 1'b1;
                        own_next    = OWN_WRITE;
                        status      = ST_GRANTED;
                    end
                end
            end
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_reg.status       <= status;
            res_reg.wake_readers <= wake_r;
            res_reg.wake_writer  <= wake_w;
            res_reg.readers_now  <= readers_next;
            res_reg.writer_now   <= writer_next;
            res_reg.lock_idle    <= (readers_next == 9'd0) && !writer_next
                                    && (wait_r_next == 5'd0) && (wait_w_next == 5'd0);
        end
    end

    assign out_data = res_reg;

    // Update lock state, configuration and the thread table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefer_reg  <= 1'b0;
            writer_reg  <= 1'b0;
            readers_reg <= 9'd0;
            wait_r_reg  <= 5'd0;
            wait_w_reg  <= 5'd0;
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                owned_reg[i] <= 10'd0;
                pend_reg[i]  <= PEND_NONE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                prefer_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                writer_reg     <= writer_next;
                readers_reg    <= readers_next;
                wait_r_reg     <= wait_r_next;
                wait_w_reg     <= wait_w_next;
                owned_reg[tid] <= own_next;
                pend_reg[tid]  <= pend_next;
            end
        end
    end

endmodule
